[rtl/ddc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_pkg
// Types, constants and calendar tables shared by the date difference counter.
// ----------------------------------------------------------------------------
package ddc_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int COUNT_W  = 22;

  // shared multiplier operand and product widths
  localparam int MUL_A_W  = 14;
  localparam int MUL_B_W  = 13;
  localparam int PROD_W   = 27;

  // quotient by 100 of a year fits in 8 bits (at most 99)
  localparam int QUOT_W   = 8;
  localparam int DOY_W    = 9;

  localparam logic [YEAR_W-1:0]  MIN_YEAR   = 14'd1;
  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
  localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
  localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
  localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;

  // y / 100 == (y * RECIP_100) >> RECIP_SHIFT for every y below 10000
  localparam logic [MUL_B_W-1:0] RECIP_100    = 13'd5243;
  localparam int                 RECIP_SHIFT  = 19;
  localparam logic [MUL_B_W-1:0] CENTURY      = 13'd100;
  localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = 13'd365;

  localparam logic [COUNT_W-1:0] MAX_COUNT = 22'd3652059;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULQ,   // issue y * reciprocal of 100
    ST_MULR,   // take y / 100, issue (y / 100) * 100
    ST_MULN,   // resolve leap year and century count, issue (y - 1) * 365
    ST_SUM1,   // year part of the ordinal
    ST_SUM2,   // month and day part of the ordinal
    ST_DIFF    // difference of the two ordinals
  } state_t;

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before m of a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/ddc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_mul
// Shared registered multiplier: one product per cycle, the product shows in the cycle after its operands.
// ----------------------------------------------------------------------------
module ddc_mul (
  input  logic                        clk,
  input  logic [ddc_pkg::MUL_A_W-1:0] a,
  input  logic [ddc_pkg::MUL_B_W-1:0] b,
  output logic [ddc_pkg::PROD_W-1:0]  prod
);
  import ddc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

[rtl/date_difference_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_difference_counter_core
// Days from a start date to an end date on the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// command   in         start, busy         start_day/month/year, end_day/month/year,
//                                          count_end_day
// result    out        done (1-cycle)      day_count
//
// A transaction is taken at a rising edge with start high and busy low.
// Each date is turned into a day ordinal in five steps that share one
// registered multiplier (y/100 by reciprocal, century remainder, 365 * years),
// so the block stays busy through both dates and the difference step, and done pulses in the first cycle after busy.
// One transaction is in flight at a time; a new one may start in the done cycle.
// The result cannot be stalled: done marks day_count for exactly one cycle.
// Synchronous reset drops any transaction in flight and clears done.
// ----------------------------------------------------------------------------
module date_difference_counter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ddc_pkg::DAY_W-1:0]   start_day,
  input  logic [ddc_pkg::MONTH_W-1:0] start_month,
  input  logic [ddc_pkg::YEAR_W-1:0]  start_year,
  input  logic [ddc_pkg::DAY_W-1:0]   end_day,
  input  logic [ddc_pkg::MONTH_W-1:0] end_month,
  input  logic [ddc_pkg::YEAR_W-1:0]  end_year,
  input  logic                        count_end_day,
  output logic                        done,
  output logic [ddc_pkg::COUNT_W-1:0] day_count
);
  import ddc_pkg::*;

  state_t state, state_next;

  // captured transaction; year and month are clamped on capture
  logic [DAY_W-1:0]   day_a, day_b;
  logic [MONTH_W-1:0] month_a, month_b;
  logic [YEAR_W-1:0]  year_a, year_b;
  logic               flag;
  logic               sel;        // 0 while working the start date, 1 for the end date

  logic [QUOT_W-1:0]  quot;       // y / 100
  logic [QUOT_W-1:0]  cent;       // (y - 1) / 100
  logic               leap;
  logic [COUNT_W-1:0] acc;
  logic [COUNT_W-1:0] ord_a;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic [DAY_W-1:0]   cur_day;
  logic [MONTH_W-1:0] cur_month;
  logic [YEAR_W-1:0]  cur_year;
  logic [YEAR_W-1:0]  prev_year;
  logic [YEAR_W-1:0]  rem;
  logic [DAY_W-1:0]   len;
  logic [DAY_W-1:0]   day_clamped;
  logic [COUNT_W-1:0] year_part;
  logic [COUNT_W-1:0] ord_total;
  logic [COUNT_W-1:0] diff;

  function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] r;
    if (y < MIN_YEAR)      r = MIN_YEAR;
    else if (y > MAX_YEAR) r = MAX_YEAR;
    else                   r = y;
    return r;
  endfunction

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    if (m < FIRST_MONTH)     r = FIRST_MONTH;
    else if (m > LAST_MONTH) r = LAST_MONTH;
    else                     r = m;
    return r;
  endfunction

  ddc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // select the date under work
  assign cur_day   = sel ? day_b   : day_a;
  assign cur_month = sel ? month_b : month_a;
  assign cur_year  = sel ? year_b  : year_a;
  assign prev_year = cur_year - YEAR_W'(1);

  // remainder of y by 100, valid in ST_MULN while prod holds (y / 100) * 100
  assign rem = cur_year - prod[YEAR_W-1:0];

  // 365 * (y-1) + (y-1)/4 - (y-1)/100 + (y-1)/400, valid in ST_SUM1
  assign year_part = prod[COUNT_W-1:0]
                   + COUNT_W'(prev_year >> 2)
                   - COUNT_W'(cent)
                   + COUNT_W'(cent >> 2);

  // clamp the day to its month, then add month and day offsets
  assign len = month_length(cur_month, leap);
  always_comb begin
    if (cur_day < FIRST_DAY) day_clamped = FIRST_DAY;
    else if (cur_day > len)  day_clamped = len;
    else                     day_clamped = cur_day;
  end

  assign ord_total = acc
                   + COUNT_W'(days_before(cur_month))
                   + COUNT_W'(leap && (cur_month > FEBRUARY))
                   + COUNT_W'(day_clamped);

  // acc holds the end ordinal in ST_DIFF
  assign diff = (ord_a < acc) ? (acc - ord_a) : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_MULQ;
      ST_MULQ: state_next = ST_MULR;
      ST_MULR: state_next = ST_MULN;
      ST_MULN: state_next = ST_SUM1;
      ST_SUM1: state_next = ST_SUM2;
      ST_SUM2: state_next = sel ? ST_DIFF : ST_MULQ;
      ST_DIFF: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operands
  always_comb begin
    busy  = (state != ST_IDLE);
    mul_a = cur_year;
    mul_b = RECIP_100;
    case (state)
      ST_MULQ: begin
        mul_a = cur_year;
        mul_b = RECIP_100;
      end
      ST_MULR: begin
        mul_a = MUL_A_W'(prod[RECIP_SHIFT +: QUOT_W]);
        mul_b = CENTURY;
      end
      ST_MULN: begin
        mul_a = prev_year;
        mul_b = DAYS_PER_YEAR;
      end
      default: begin
        mul_a = cur_year;
        mul_b = RECIP_100;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DIFF);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          day_a   <= start_day;
          month_a <= clamp_month(start_month);
          year_a  <= clamp_year(start_year);
          day_b   <= end_day;
          month_b <= clamp_month(end_month);
          year_b  <= clamp_year(end_year);
          flag    <= count_end_day;
          sel     <= 1'b0;
        end
      end
      ST_MULR: begin
        quot <= prod[RECIP_SHIFT +: QUOT_W];
      end
      ST_MULN: begin
        // a century year is leap only when divisible by 400
        if (rem == '0) begin
          leap <= (quot[1:0] == 2'b00);
          cent <= quot - QUOT_W'(1);
        end else begin
          leap <= (cur_year[1:0] == 2'b00);
          cent <= quot;
        end
      end
      ST_SUM1: begin
        acc <= year_part;
      end
      ST_SUM2: begin
        acc <= ord_total;
        if (!sel) ord_a <= ord_total;
        sel <= 1'b1;
      end
      ST_DIFF: begin
        day_count <= diff + COUNT_W'(flag);
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/ddc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_checker
// Port-level checks on the date difference counter, bound to the top level.
// ----------------------------------------------------------------------------
module ddc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [ddc_pkg::COUNT_W-1:0] day_count
);
  import ddc_pkg::*;

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // the result shows only once the work is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // a result is announced once per transaction
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // busy falls only by delivering a result
  a_busy_to_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // the count never exceeds the span of the calendar
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (day_count <= MAX_COUNT))
    else $error("day_count out of range");

endmodule

bind date_difference_counter_core ddc_checker u_ddc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .day_count (day_count)
);

[tb/day_count_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_checker
// Watches the command and result channels of the date difference counter,
// predicts each day count from the accepted dates and compares the results
// in order against the predictions.
// ----------------------------------------------------------------------------
module day_count_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [ddc_pkg::DAY_W-1:0]   start_day,
  input  logic [ddc_pkg::MONTH_W-1:0] start_month,
  input  logic [ddc_pkg::YEAR_W-1:0]  start_year,
  input  logic [ddc_pkg::DAY_W-1:0]   end_day,
  input  logic [ddc_pkg::MONTH_W-1:0] end_month,
  input  logic [ddc_pkg::YEAR_W-1:0]  end_year,
  input  logic                        count_end_day,
  input  logic                        done,
  input  logic [ddc_pkg::COUNT_W-1:0] day_count,
  output int                          fail_count,
  output int                          pending_count,
  output int                          result_count
);

  import ddc_pkg::*;

  localparam int unsigned COMMON_FEB_DAYS = 28;
  localparam int unsigned LEAP_FEB_DAYS   = 29;
  localparam int          MAX_REPORTS     = 10;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [DAY_W-1:0]   sd;
    logic [MONTH_W-1:0] sm;
    logic [YEAR_W-1:0]  sy;
    logic [DAY_W-1:0]   ed;
    logic [MONTH_W-1:0] em;
    logic [YEAR_W-1:0]  ey;
    logic               flag;
  } day_count_entry_t;

  day_count_entry_t expected_day_counts[$];
  int               mismatches = 0;
  int               results_seen = 0;

  assign fail_count    = mismatches;
  assign pending_count = expected_day_counts.size();
  assign result_count  = results_seen;

  function automatic bit gregorian_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_len_of(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      2:           len = gregorian_leap(y) ? LEAP_FEB_DAYS : COMMON_FEB_DAYS;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // ordinal of a date with 1 January of year 1 as day 1; out-of-range fields clamp
  function automatic int unsigned date_ordinal(input logic [DAY_W-1:0] dd,
                                               input logic [MONTH_W-1:0] mm,
                                               input logic [YEAR_W-1:0] yy);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned p;
    int unsigned n;
    int unsigned len;
    y = 32'(yy);
    m = 32'(mm);
    d = 32'(dd);
    if (y < MIN_YEAR) y = MIN_YEAR;
    if (y > MAX_YEAR) y = MAX_YEAR;
    if (m < FIRST_MONTH) m = FIRST_MONTH;
    if (m > LAST_MONTH) m = LAST_MONTH;
    len = month_len_of(y, m);
    if (d < FIRST_DAY) d = FIRST_DAY;
    if (d > len) d = len;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned i = FIRST_MONTH; i < m; i++) n += month_len_of(y, i);
    return n + d;
  endfunction

  function automatic logic [COUNT_W-1:0] predict_day_count(input day_count_entry_t e);
    int unsigned a;
    int unsigned b;
    int unsigned cnt;
    a = date_ordinal(e.sd, e.sm, e.sy);
    b = date_ordinal(e.ed, e.em, e.ey);
    cnt = (a < b) ? (b - a) : 0;
    cnt += 32'(e.flag);
    return cnt[COUNT_W-1:0];
  endfunction

  always @(posedge clk) begin
    day_count_entry_t e;
    day_count_entry_t got;
    if (!rst) begin
      // retire the oldest prediction first: a new command may land in the done cycle
      if (done) begin
        results_seen++;
        if (expected_day_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("day_count_checker: unexpected result %0d with nothing pending",
                     day_count);
        end else begin
          got = expected_day_counts.pop_front();
          if (day_count !== got.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("day_count_checker: %0d/%0d/%0d -> %0d/%0d/%0d flag %0b: %s %0d, got %0d",
                       got.sd, got.sm, got.sy, got.ed, got.em, got.ey, got.flag,
                       "expected", got.count, day_count);
          end
        end
      end
      if (start && !busy) begin
        e.sd   = start_day;
        e.sm   = start_month;
        e.sy   = start_year;
        e.ed   = end_day;
        e.em   = end_month;
        e.ey   = end_year;
        e.flag = count_end_day;
        e.count = predict_day_count(e);
        expected_day_counts.push_back(e);
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives date pairs into the date difference counter: directed calendar
// edges first, then random spans, with idle bursts; the checker beside the
// block predicts and compares every day count.
// ----------------------------------------------------------------------------
module tb_top;

  import ddc_pkg::*;

  localparam int NUM_RANDOM     = 560;
  localparam int QUIET_TAIL     = 100;   // last commands go back to back
  localparam int DRAIN_LATENCY  = 30;    // wait after the last result for stray pulses
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [DAY_W-1:0]   start_day = '0;
  logic [MONTH_W-1:0] start_month = '0;
  logic [YEAR_W-1:0]  start_year = '0;
  logic [DAY_W-1:0]   end_day = '0;
  logic [MONTH_W-1:0] end_month = '0;
  logic [YEAR_W-1:0]  end_year = '0;
  logic               count_end_day = 1'b0;
  logic               done;
  logic [COUNT_W-1:0] day_count;

  int fail_count;
  int pending_count;
  int result_count;
  int commands_sent = 0;
  int directed_sent = 0;
  int idle_cycles = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  date_difference_counter_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .end_day       (end_day),
    .end_month     (end_month),
    .end_year      (end_year),
    .count_end_day (count_end_day),
    .done          (done),
    .day_count     (day_count)
  );

  day_count_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .end_day       (end_day),
    .end_month     (end_month),
    .end_year      (end_year),
    .count_end_day (count_end_day),
    .done          (done),
    .day_count     (day_count),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  // Watchdog: count cycles in which neither a command nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_top: watchdog expired, %0d results still pending", pending_count);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one command at the falling edge and hold it until a rising edge
  // sees busy low. Start stays high if the next command follows at once.
  task automatic send_dates(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                            input logic [YEAR_W-1:0] sy, input logic [DAY_W-1:0] ed,
                            input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey,
                            input logic flag);
    @(negedge clk);
    start         <= 1'b1;
    start_day     <= sd;
    start_month   <= sm;
    start_year    <= sy;
    end_day       <= ed;
    end_month     <= em;
    end_year      <= ey;
    count_end_day <= flag;
    @(posedge clk);
    while (busy) @(posedge clk);
    commands_sent++;
  endtask

  // Drop start for an idle burst; n sets its length.
  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic int unsigned month_span(input int unsigned y, input int unsigned m);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Pick a well-formed date with its year in [ylo, yhi].
  task automatic pick_date(input int unsigned ylo, input int unsigned yhi,
                           output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                           output logic [YEAR_W-1:0] y);
    int unsigned yy;
    int unsigned mm;
    yy = $urandom_range(yhi, ylo);
    mm = $urandom_range(LAST_MONTH, FIRST_MONTH);
    y = YEAR_W'(yy);
    m = MONTH_W'(mm);
    d = DAY_W'($urandom_range(month_span(yy, mm), FIRST_DAY));
  endtask

  initial begin
    logic [DAY_W-1:0]   sd;
    logic [MONTH_W-1:0] sm;
    logic [YEAR_W-1:0]  sy;
    logic [DAY_W-1:0]   ed;
    logic [MONTH_W-1:0] em;
    logic [YEAR_W-1:0]  ey;
    int unsigned        yy;
    int                 kind;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: same date, full range, reversed, leap and century rules, clamping.
    send_dates(5'd15, 4'd6, 14'd2020, 5'd15, 4'd6, 14'd2020, 1'b0);
    send_dates(5'd15, 4'd6, 14'd2020, 5'd15, 4'd6, 14'd2020, 1'b1);
    send_dates(5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, 1'b1);
    send_dates(5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, 1'b0);
    send_dates(5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1, 1'b1);
    send_dates(5'd10, 4'd3, 14'd1500, 5'd11, 4'd3, 14'd1500, 1'b0);
    send_dates(5'd31, 4'd12, 14'd1999, 5'd1, 4'd1, 14'd2000, 1'b0);
    send_dates(5'd28, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000, 1'b0);
    send_dates(5'd28, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900, 1'b0);
    send_dates(5'd28, 4'd2, 14'd2024, 5'd1, 4'd3, 14'd2024, 1'b1);
    send_dates(5'd28, 4'd2, 14'd2023, 5'd1, 4'd3, 14'd2023, 1'b0);
    // out-of-range days, months and years
    send_dates(5'd0, 4'd0, 14'd0, 5'd0, 4'd0, 14'd0, 1'b1);
    send_dates(5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383, 1'b0);
    send_dates(5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'd16383, 1'b0);
    send_dates(5'd31, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900, 1'b0);
    send_dates(5'd30, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000, 1'b0);
    send_dates(5'd29, 4'd2, 14'd2023, 5'd1, 4'd3, 14'd2023, 1'b0);
    send_dates(5'd31, 4'd4, 14'd2010, 5'd1, 4'd5, 14'd2010, 1'b0);
    send_dates(5'd1, 4'd13, 14'd10000, 5'd1, 4'd1, 14'd9999, 1'b1);
    send_dates(5'd1, 4'd14, 14'd5000, 5'd1, 4'd0, 14'd5001, 1'b0);
    send_dates(5'd1, 4'd1, 14'd8192, 5'd31, 4'd12, 14'd8191, 1'b1);
    send_dates(5'd1, 4'd1, 14'd1, 5'd1, 4'd1, 14'd2, 1'b0);
    directed_sent = commands_sent;

    // Random: half short spans of well-formed dates, plus wide spans,
    // calendar edges, reversed pairs and raw bit noise.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      kind = $urandom_range(99, 0);
      if (kind < 50) begin
        pick_date(MIN_YEAR, MAX_YEAR, sd, sm, sy);
        yy = sy + $urandom_range(4, 0);
        if (yy > MAX_YEAR) yy = MAX_YEAR;
        pick_date(yy, yy, ed, em, ey);
      end else if (kind < 65) begin
        pick_date(MIN_YEAR, MAX_YEAR, sd, sm, sy);
        pick_date(MIN_YEAR, MAX_YEAR, ed, em, ey);
      end else if (kind < 80) begin
        // leap day and century boundaries
        yy = ($urandom_range(1, 0) == 1) ? $urandom_range(99, 1) * 100
                                         : $urandom_range(2499, 1) * 4;
        sy = YEAR_W'(yy);
        sm = ($urandom_range(1, 0) == 1) ? 4'd2 : LAST_MONTH;
        sd = (sm == LAST_MONTH) ? 5'd31 : 5'($urandom_range(29, 28));
        ey = (yy + $urandom_range(1, 0) > MAX_YEAR) ? MAX_YEAR[YEAR_W-1:0]
                                                    : YEAR_W'(yy + $urandom_range(1, 0));
        em = 4'($urandom_range(3, 1));
        ed = 5'($urandom_range(month_span(ey, em), FIRST_DAY));
      end else if (kind < 88) begin
        // end year not after start year, or the very same date
        pick_date(MIN_YEAR, MAX_YEAR, sd, sm, sy);
        if ($urandom_range(1, 0) == 1) begin
          ed = sd;
          em = sm;
          ey = sy;
        end else begin
          yy = $urandom_range(sy, MIN_YEAR);
          pick_date(yy, yy, ed, em, ey);
        end
      end else begin
        sd = DAY_W'($urandom);
        sm = MONTH_W'($urandom);
        sy = YEAR_W'($urandom);
        ed = DAY_W'($urandom);
        em = MONTH_W'($urandom);
        ey = YEAR_W'($urandom);
      end

      send_dates(sd, sm, sy, ed, em, ey, 1'($urandom));

      // hold off once until every pending result is back
      if (i == NUM_RANDOM / 2) begin
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end

      // random idle bursts, none in the closing stretch
      if (i < NUM_RANDOM - QUIET_TAIL && $urandom_range(3, 0) == 0)
        hold_off($urandom_range(12, 1));
    end

    // Drain: wait for the last results, then give stray pulses time to show.
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_LATENCY) @(negedge clk);

    $display("tb_top: %0d commands (%0d directed), %0d results compared",
             commands_sent, directed_sent, result_count);
    $display("tb_top: covered leap and century rules, field clamping, reversed and wide spans");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d failures, %0d results missing", fail_count, pending_count);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
